### rtl/core/sbusfd_pkg.sv
// Shared types and constants for the SBUS frame decoder.
package sbusfd_pkg;

	localparam logic [7:0] START_BYTE   = 8'h0F;
	localparam int         PAYLOAD_LEN  = 22;
	localparam int         NUM_CHANNELS = 16;
	localparam int         CHAN_W       = 11;
	localparam int         PAYLOAD_BITS = PAYLOAD_LEN * 8;
	localparam int         FLAG_LOST    = 2;
	localparam int         FLAG_FS      = 3;
	localparam logic [7:0] END_BYTE_A   = 8'h04;
	localparam logic [7:0] END_BYTE_B   = 8'h14;
	localparam logic [7:0] END_BYTE_C   = 8'h24;
	localparam logic [7:0] END_BYTE_D   = 8'h34;
	localparam int         CNT_W        = $clog2(PAYLOAD_LEN + 1);
	localparam int         IDX_W        = $clog2(NUM_CHANNELS);

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_PAYLOAD,
		PH_FLAGS,
		PH_END
	} phase_t;

	typedef struct packed {
		logic                    load;
		logic                    failsafe;
		logic [PAYLOAD_BITS-1:0] bits;
	} frame_t;

endpackage

### rtl/core/sbus_frame_decoder.sv
// SBUS frame decoder top level: byte parser and channel result emitter.
//
//  channel | signals                          | beat
//  --------+----------------------------------+------------------------------------
//  in      | in_valid, in_stall, byte_value   | one received byte
//  out     | out_valid, out_stall,            | one channel: index, 11-bit value,
//          | channel_index, channel_value,    | failsafe flag, last marker
//          | failsafe_active, last_channel    |
//
// One input byte per cycle while in_stall is low. A good frame is copied on its end byte into an
// output shift register that yields 16 beats, one per cycle while out_stall is low.
// The end byte of a following frame is held (in_stall) while those beats are
// still pending; all other bytes are taken at once.
// Reset clears the parse phase, the byte count and the output valid.
module sbus_frame_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    byte_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [3:0]                    channel_index,
	output logic [10:0]                   channel_value,
	output logic                          failsafe_active,
	output logic                          last_channel
);

	sbusfd_pkg::frame_t                       frame;
	logic                                     busy_q;
	logic [sbusfd_pkg::IDX_W-1:0]             ch_q;
	logic [sbusfd_pkg::PAYLOAD_BITS-1:0]      shift_q;
	logic                                     fs_q;
	logic                                     out_fire;
	logic                                     is_last;

	sbusfd_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.byte_value (byte_value),
		.emit_busy  (busy_q),
		.frame      (frame)
	);

	assign is_last  = (ch_q == sbusfd_pkg::IDX_W'(sbusfd_pkg::NUM_CHANNELS - 1));
	assign out_fire = busy_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ch_q   <= '0;
		end else begin
			if (frame.load) begin
				busy_q <= 1'b1;
				ch_q   <= '0;
			end else if (out_fire) begin
				busy_q <= !is_last;
				ch_q   <= ch_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (frame.load) begin
			shift_q <= frame.bits;
			fs_q    <= frame.failsafe;
		end else if (out_fire) begin
			shift_q <= shift_q >> sbusfd_pkg::CHAN_W;
		end
	end

	assign out_valid       = busy_q;
	assign channel_index   = ch_q;
	assign channel_value   = shift_q[sbusfd_pkg::CHAN_W-1:0];
	assign failsafe_active = fs_q;
	assign last_channel    = is_last;

endmodule

### rtl/core/sbusfd_parse.sv
// Byte parser: start hunt, payload shift line, flags and end-byte check.
module sbusfd_parse (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            byte_value,
	input  logic                  emit_busy,
	output sbusfd_pkg::frame_t    frame
);

	sbusfd_pkg::phase_t                 phase_q;
	sbusfd_pkg::phase_t                 phase_d;
	logic [sbusfd_pkg::CNT_W-1:0]       count_q;
	logic [sbusfd_pkg::CNT_W-1:0]       count_d;
	logic [7:0]                         pay_q [sbusfd_pkg::PAYLOAD_LEN];
	logic [7:0]                         flags_q;
	logic                               fire;
	logic                               end_ok;

	assign in_stall = (phase_q == sbusfd_pkg::PH_END) && emit_busy;
	assign fire     = in_valid && !in_stall;

	assign end_ok = (byte_value == sbusfd_pkg::END_BYTE_A) ||
	                (byte_value == sbusfd_pkg::END_BYTE_B) ||
	                (byte_value == sbusfd_pkg::END_BYTE_C) ||
	                (byte_value == sbusfd_pkg::END_BYTE_D);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sbusfd_pkg::PH_HUNT;
			count_q <= '0;
		end else begin
			phase_q <= phase_d;
			count_q <= count_d;
		end
	end

	always_comb begin
		for (int i = 0; i < sbusfd_pkg::PAYLOAD_LEN; i++) begin
			frame.bits[i*8 +: 8] = pay_q[i];
		end
		frame.failsafe = flags_q[sbusfd_pkg::FLAG_FS];
		phase_d    = phase_q;
		count_d    = count_q;
		frame.load = 1'b0;
		if (fire) begin
			unique case (phase_q)
				sbusfd_pkg::PH_HUNT: begin
					if (byte_value == sbusfd_pkg::START_BYTE) begin
						count_d = '0;
						phase_d = sbusfd_pkg::PH_PAYLOAD;
					end
				end
				sbusfd_pkg::PH_PAYLOAD: begin
					count_d = count_q + 1'b1;
					if (count_d >= sbusfd_pkg::CNT_W'(sbusfd_pkg::PAYLOAD_LEN)) begin
						phase_d = sbusfd_pkg::PH_FLAGS;
					end
				end
				sbusfd_pkg::PH_FLAGS: begin
					phase_d = sbusfd_pkg::PH_END;
				end
				sbusfd_pkg::PH_END: begin
					phase_d    = sbusfd_pkg::PH_HUNT;
					frame.load = end_ok && !flags_q[sbusfd_pkg::FLAG_LOST];
				end
				default: begin
					phase_d = sbusfd_pkg::PH_HUNT;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fire && phase_q == sbusfd_pkg::PH_PAYLOAD) begin
			for (int i = 0; i < sbusfd_pkg::PAYLOAD_LEN - 1; i++) begin
				pay_q[i] <= pay_q[i+1];
			end
			pay_q[sbusfd_pkg::PAYLOAD_LEN-1] <= byte_value;
		end
		if (fire && phase_q == sbusfd_pkg::PH_FLAGS) begin
			flags_q <= byte_value;
		end
	end

endmodule

### tb/sv/tb_sbus_frame_decoder.sv
// Testbench for sbus_frame_decoder: random byte streams with a frame-level checker.
`timescale 1ns / 1ps

module tb_sbus_frame_decoder;

	typedef struct packed {
		logic [sbusfd_pkg::IDX_W-1:0]  idx;
		logic [sbusfd_pkg::CHAN_W-1:0] value;
		logic                          failsafe;
		logic                          last;
	} chan_beat_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [7:0]        byte_value = 8'h00;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [3:0]        channel_index;
	logic [10:0]       channel_value;
	logic              failsafe_active;
	logic              last_channel;

	logic [7:0]        bytes_to_send [$];
	chan_beat_t        channel_beats_due [$];

	sbusfd_pkg::phase_t rx_phase = sbusfd_pkg::PH_HUNT;
	int                rx_count = 0;
	logic [sbusfd_pkg::PAYLOAD_BITS-1:0] rx_payload = '0;
	logic [7:0]        rx_flags = 8'h00;

	int                bytes_issued = 0;
	int                bytes_taken = 0;
	int                beats_taken = 0;
	int                beats_seen = 0;
	int                error_count = 0;
	int                send_wait = 0;
	int                send_calm = 0;
	int                recv_wait = 0;
	int                recv_calm = 0;
	int                hold_cycles = 0;
	bit                hold_done = 1'b0;

	sbus_frame_decoder u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.byte_value      (byte_value),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.channel_index   (channel_index),
		.channel_value   (channel_value),
		.failsafe_active (failsafe_active),
		.last_channel    (last_channel)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int draw_wait(inout int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 9) == 0) begin
			calm_left = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 11);
	endfunction

	function automatic void decode_rx_byte(input logic [7:0] b);
		chan_beat_t beat;
		case (rx_phase)
			sbusfd_pkg::PH_HUNT: begin
				if (b == sbusfd_pkg::START_BYTE) begin
					rx_count = 0;
					rx_phase = sbusfd_pkg::PH_PAYLOAD;
				end
			end
			sbusfd_pkg::PH_PAYLOAD: begin
				rx_payload[8*rx_count +: 8] = b;
				rx_count++;
				if (rx_count >= sbusfd_pkg::PAYLOAD_LEN)
					rx_phase = sbusfd_pkg::PH_FLAGS;
			end
			sbusfd_pkg::PH_FLAGS: begin
				rx_flags = b;
				rx_phase = sbusfd_pkg::PH_END;
			end
			default: begin
				rx_phase = sbusfd_pkg::PH_HUNT;
				if ((b == sbusfd_pkg::END_BYTE_A || b == sbusfd_pkg::END_BYTE_B ||
						b == sbusfd_pkg::END_BYTE_C || b == sbusfd_pkg::END_BYTE_D)
						&& !rx_flags[sbusfd_pkg::FLAG_LOST]) begin
					for (int ch = 0; ch < sbusfd_pkg::NUM_CHANNELS; ch++) begin
						beat.idx      = sbusfd_pkg::IDX_W'(ch);
						beat.value    = rx_payload[sbusfd_pkg::CHAN_W*ch +: sbusfd_pkg::CHAN_W];
						beat.failsafe = rx_flags[sbusfd_pkg::FLAG_FS];
						beat.last     = (ch == sbusfd_pkg::NUM_CHANNELS - 1);
						channel_beats_due.push_back(beat);
					end
				end
			end
		endcase
	endfunction

	// fill_mode: 0 random, 1 all zero, 2 all ones
	function automatic void queue_frame(input logic [7:0] flags, input logic [7:0] tail,
			input int fill_mode);
		bytes_to_send.push_back(sbusfd_pkg::START_BYTE);
		for (int i = 0; i < sbusfd_pkg::PAYLOAD_LEN; i++) begin
			case (fill_mode)
				1: bytes_to_send.push_back(8'h00);
				2: bytes_to_send.push_back(8'hFF);
				default: bytes_to_send.push_back(8'($urandom_range(0, 255)));
			endcase
		end
		bytes_to_send.push_back(flags);
		bytes_to_send.push_back(tail);
	endfunction

	function automatic logic [7:0] good_tail();
		case ($urandom_range(0, 3))
			0: return sbusfd_pkg::END_BYTE_A;
			1: return sbusfd_pkg::END_BYTE_B;
			2: return sbusfd_pkg::END_BYTE_C;
			default: return sbusfd_pkg::END_BYTE_D;
		endcase
	endfunction

	// driver: present the next byte on the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && bytes_taken == bytes_issued)
				send_wait = (hold_cycles > 0) ? 0 : draw_wait(send_calm);
			if (!in_valid || bytes_taken == bytes_issued) begin
				if (send_wait > 0 || bytes_to_send.size() == 0) begin
					in_valid <= 1'b0;
					if (send_wait > 0)
						send_wait--;
				end else begin
					in_valid <= 1'b1;
					byte_value <= bytes_to_send.pop_front();
					bytes_issued++;
				end
			end
		end
	end

	// receiver: random stall before each beat, longer hold once
	always @(negedge clk) begin
		if (arst_n) begin
			if (beats_taken != beats_seen) begin
				beats_seen = beats_taken;
				recv_wait = draw_wait(recv_calm);
			end
			if (hold_cycles > 0 || recv_wait > 0) begin
				out_stall <= 1'b1;
				if (recv_wait > 0)
					recv_wait--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!hold_done && beats_taken >= 48) begin
			hold_cycles = 400;
			hold_done = 1'b1;
		end else if (hold_cycles > 0) begin
			hold_cycles--;
		end
	end

	// monitor: predict on accepted bytes, check accepted beats
	always @(posedge clk) begin : monitor
		chan_beat_t want;
		chan_beat_t got;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				decode_rx_byte(byte_value);
				bytes_taken++;
			end
			if (out_valid && !out_stall) begin
				beats_taken++;
				got = {channel_index, channel_value, failsafe_active, last_channel};
				if (channel_beats_due.size() == 0) begin
					if (error_count < 10)
						$display("unexpected beat: idx %0d value %0d fs %0b last %0b",
							got.idx, got.value, got.failsafe, got.last);
					error_count++;
				end else begin
					want = channel_beats_due.pop_front();
					if (got.idx !== want.idx || got.value !== want.value ||
							got.failsafe !== want.failsafe || got.last !== want.last) begin
						if (error_count < 10)
							$display({"mismatch: exp idx %0d value %0d fs %0b last %0b,",
								" got idx %0d value %0d fs %0b last %0b"},
								want.idx, want.value, want.failsafe, want.last,
								got.idx, got.value, got.failsafe, got.last);
						error_count++;
					end
				end
			end
		end
	end

	initial begin : stimulus
		int pick;
		int drain;
		logic [7:0] flags;

		// hunting noise, then one frame with extreme values and a start byte inside
		bytes_to_send.push_back(8'h00);
		bytes_to_send.push_back(8'hFF);
		bytes_to_send.push_back(sbusfd_pkg::START_BYTE);
		for (int i = 0; i < sbusfd_pkg::PAYLOAD_LEN; i++)
			bytes_to_send.push_back(i < 11 ? 8'hFF :
				(i == 11 ? sbusfd_pkg::START_BYTE : 8'h00));
		bytes_to_send.push_back(8'h08);
		bytes_to_send.push_back(sbusfd_pkg::END_BYTE_D);

		while (bytes_to_send.size() < 330) begin
			pick = $urandom_range(0, 99);
			flags = 8'($urandom_range(0, 255));
			if (pick < 70) begin
				flags[sbusfd_pkg::FLAG_LOST] = 1'b0;
				queue_frame(flags, good_tail(), $urandom_range(0, 9) == 0 ? 1 :
					($urandom_range(0, 9) == 0 ? 2 : 0));
			end else if (pick < 80) begin
				flags[sbusfd_pkg::FLAG_LOST] = 1'b1;
				queue_frame(flags, good_tail(), 0);
			end else if (pick < 88) begin
				flags[sbusfd_pkg::FLAG_LOST] = 1'b0;
				queue_frame(flags, $urandom_range(0, 1) ? 8'h44 :
					8'($urandom_range(0, 255)), 0);
			end else if (pick < 93) begin
				bytes_to_send.push_back(sbusfd_pkg::START_BYTE);
				repeat ($urandom_range(1, 20))
					bytes_to_send.push_back(8'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(1, 6))
					bytes_to_send.push_back(8'($urandom_range(0, 255)));
			end
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (bytes_to_send.size() > 0 || bytes_taken != bytes_issued)
			@(posedge clk);
		drain = 0;
		while (channel_beats_due.size() > 0 && drain < 5000) begin
			@(posedge clk);
			drain++;
		end
		repeat (40) @(posedge clk);
		if (channel_beats_due.size() > 0) begin
			if (error_count < 10)
				$display("%0d channel beats never arrived", channel_beats_due.size());
			error_count++;
		end

		if (error_count == 0)
			$display("tb_sbus_frame_decoder passed");
		else
			$display("tb_sbus_frame_decoder failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb_sbus_frame_decoder failed");
		$finish;
	end

endmodule
